### src/awfd_pkg.sv
// Package for the acoustic wave update pipeline.
// Register indexes, reset values, pipeline depth and the divide-by-3 constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package awfd_pkg;

  // Register stages from input acceptance to the output register.
  localparam int unsigned NSTG = 11;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_INV_DZ_SQ = 2'd0,
    CFG_INV_DX_SQ = 2'd1,
    CFG_DT_STEP   = 2'd2
  } awfd_cfg_idx_e;

  localparam logic [31:0] INV_DZ_SQ_RST = 32'd16777216;  // 1.0 in Q8.24
  localparam logic [31:0] INV_DX_SQ_RST = 32'd16777216;  // 1.0 in Q8.24
  localparam logic [31:0] DT_STEP_RST   = 32'd4294967;   // ~0.001 in Q0.32

  // floor(u / 3) = (u * DIV3_RECIP) >> DIV3_SHIFT for u < 2^38
  localparam int unsigned DIV3_SHIFT = 40;
  localparam logic [38:0] DIV3_RECIP = 39'd366503875926;  // (2^40 + 2) / 3
  // Offset that makes the dividend non-negative; removed again after division.
  localparam logic [37:0] DIV3_BIAS  = 38'd103079215104;  // 3 * 2^35
  localparam logic [36:0] DIV3_UNBIAS = 37'd34359738368;  // 2^35

  // Stage enables of the divide unit.
  typedef struct packed {
    logic en_a;
    logic en_b;
  } awfd_div_en_t;

endpackage

`default_nettype wire

### src/awfd_div3.sv
// Two-stage floor divide by 3 using a split reciprocal multiply.
// Depends on awfd_pkg (reciprocal, shift, unbias offset, enable struct).
`timescale 1ns / 1ps
`default_nettype none

module awfd_div3 (
  input  wire                          clk_i,
  input  awfd_pkg::awfd_div_en_t       en_i,
  input  wire  [37:0]                  u_i,     // biased dividend
  output logic signed [36:0]           t_o      // floor(u/3) - 2^35
);

  logic [57:0] ph_q, ph_d;
  logic [57:0] pl_q, pl_d;
  logic [76:0] prod;
  logic [36:0] quo;
  logic signed [36:0] t_d;

  // stage a: two 19 x 39 partial products
  assign ph_d = u_i[37:19] * awfd_pkg::DIV3_RECIP;
  assign pl_d = u_i[18:0] * awfd_pkg::DIV3_RECIP;

  always_ff @(posedge clk_i) begin
    if (en_i.en_a) begin
      ph_q <= ph_d;
      pl_q <= pl_d;
    end
  end

  // stage b: combine, shift, remove bias
  assign prod = {ph_q, 19'b0} + {19'b0, pl_q};
  assign quo  = prod[76:awfd_pkg::DIV3_SHIFT];
  assign t_d  = $signed(quo - awfd_pkg::DIV3_UNBIAS);

  always_ff @(posedge clk_i) begin
    if (en_i.en_b) begin
      t_o <= t_d;
    end
  end

endmodule

`default_nettype wire

### src/acoustic_wave_fd_update_unit.sv
// 2-D fourth-order acoustic wave update, one grid point per request.
// Throughput: one request per cycle while out_ready_i is high; an 11-stage
// pipeline with per-stage valid bits, so bubbles collapse and a stalled
// output holds without loss.
// Reset (rst_ni low, async): pipeline emptied, scale and dt registers take
// their reset values (1.0, 1.0, ~0.001 s).
`timescale 1ns / 1ps
`default_nettype none

module acoustic_wave_fd_update_unit (
  input  wire                clk_i,
  input  wire                rst_ni,
  // configuration write port
  input  wire                cfg_we_i,
  input  wire  [1:0]         cfg_index_i,
  input  wire  [31:0]        cfg_wdata_i,
  // input request channel
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  signed [31:0] curr_center_i,
  input  wire  signed [31:0] curr_x_m2_i,
  input  wire  signed [31:0] curr_x_m1_i,
  input  wire  signed [31:0] curr_x_p1_i,
  input  wire  signed [31:0] curr_x_p2_i,
  input  wire  signed [31:0] curr_z_m2_i,
  input  wire  signed [31:0] curr_z_m1_i,
  input  wire  signed [31:0] curr_z_p1_i,
  input  wire  signed [31:0] curr_z_p2_i,
  input  wire  signed [31:0] prev_value_i,
  input  wire  [15:0]        velocity_i,
  // result channel
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [31:0] new_value_o
);

  localparam int unsigned NSTG = awfd_pkg::NSTG;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [31:0] inv_dz_sq_q;
  logic [31:0] inv_dx_sq_q;
  logic [31:0] dt_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_dz_sq_q <= awfd_pkg::INV_DZ_SQ_RST;
      inv_dx_sq_q <= awfd_pkg::INV_DX_SQ_RST;
      dt_step_q   <= awfd_pkg::DT_STEP_RST;
    end else if (cfg_we_i) begin
      case (awfd_pkg::awfd_cfg_idx_e'(cfg_index_i))
        awfd_pkg::CFG_INV_DZ_SQ: inv_dz_sq_q <= cfg_wdata_i;
        awfd_pkg::CFG_INV_DX_SQ: inv_dx_sq_q <= cfg_wdata_i;
        awfd_pkg::CFG_DT_STEP:   dt_step_q   <= cfg_wdata_i;
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control: stage i loads when it is empty or stage i+1 loads.
  // en[NSTG] is the downstream ready.
  // ---------------------------------------------------------------------
  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   en;

  always_comb begin
    en[NSTG] = out_ready_i;
    for (int i = NSTG - 1; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NSTG-1];

  // 2*curr - prev rides along to the final add
  logic signed [33:0] base_q [NSTG-1];
  logic signed [33:0] base_d;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      base_q[0] <= base_d;
    end
    for (int i = 1; i < NSTG - 1; i++) begin
      if (en[i]) begin
        base_q[i] <= base_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: 12x stencil sums per axis, base term, velocity * dt
  // S = -(m2 + p2) + 16*(m1 + p1) - 30*c, |S| < 2^38
  // ---------------------------------------------------------------------
  function automatic logic signed [39:0] axis_sum(
    input logic signed [31:0] m2,
    input logic signed [31:0] m1,
    input logic signed [31:0] c,
    input logic signed [31:0] p1,
    input logic signed [31:0] p2
  );
    logic signed [39:0] e_m2, e_m1, e_c, e_p1, e_p2;
    e_m2 = {{8{m2[31]}}, m2};
    e_m1 = {{8{m1[31]}}, m1};
    e_c  = {{8{c[31]}}, c};
    e_p1 = {{8{p1[31]}}, p1};
    e_p2 = {{8{p2[31]}}, p2};
    return ((e_m1 + e_p1) <<< 4) - (e_m2 + e_p2) - ((e_c <<< 5) - (e_c <<< 1));
  endfunction

  logic signed [39:0] sx_q, sz_q, sx_d, sz_d;
  logic [47:0]        vd_q, vd_d;

  assign sx_d = axis_sum(curr_x_m2_i, curr_x_m1_i, curr_center_i, curr_x_p1_i, curr_x_p2_i);
  assign sz_d = axis_sum(curr_z_m2_i, curr_z_m1_i, curr_center_i, curr_z_p1_i, curr_z_p2_i);
  assign base_d = ({{2{curr_center_i[31]}}, curr_center_i} <<< 1)
                - {{2{prev_value_i[31]}}, prev_value_i};
  assign vd_d = {32'b0, velocity_i} * {16'b0, dt_step_q};

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sx_q <= sx_d;
      sz_q <= sz_d;
      vd_q <= vd_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: S * scale as two 40 x 16 halves per axis; k = vdt^2 product
  // ---------------------------------------------------------------------
  logic signed [56:0] pxl_q, pxh_q, pzl_q, pzh_q;
  logic signed [56:0] pxl_d, pxh_d, pzl_d, pzh_d;
  logic [63:0]        kk_q, kk_d;

  assign pxl_d = sx_q * $signed({1'b0, inv_dx_sq_q[15:0]});
  assign pxh_d = sx_q * $signed({1'b0, inv_dx_sq_q[31:16]});
  assign pzl_d = sz_q * $signed({1'b0, inv_dz_sq_q[15:0]});
  assign pzh_d = sz_q * $signed({1'b0, inv_dz_sq_q[31:16]});
  assign kk_d  = vd_q[47:16] * vd_q[47:16];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pxl_q <= pxl_d;
      pxh_q <= pxh_d;
      pzl_q <= pzl_d;
      pzh_q <= pzh_d;
      kk_q  <= kk_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: per-axis L = floor(S * scale / 2^24), |L| < 2^46
  // ---------------------------------------------------------------------
  logic signed [72:0] px_full, pz_full;
  logic signed [47:0] lx_q, lz_q;
  logic [47:0]        k2_q;

  assign px_full = (73'(pxh_q) <<< 16) + 73'(pxl_q);
  assign pz_full = (73'(pzh_q) <<< 16) + 73'(pzl_q);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      lx_q <= px_full[71:24];
      lz_q <= pz_full[71:24];
      k2_q <= kk_q[63:16];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: Laplacian sum
  // ---------------------------------------------------------------------
  logic signed [47:0] lap_q;
  logic [47:0]        k3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      lap_q <= lx_q + lz_q;
      k3_q  <= k2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: sign and magnitude of the Laplacian
  // ---------------------------------------------------------------------
  logic [46:0] mag_q, mag_d;
  logic        neg4_q;
  logic [47:0] k4_q;

  assign mag_d = lap_q[47] ? 47'(-lap_q) : lap_q[46:0];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      mag_q  <= mag_d;
      neg4_q <= lap_q[47];
      k4_q   <= k3_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: |L| * k as two 24 x 24 and two 23 x 24 partial products
  // ---------------------------------------------------------------------
  logic [47:0] pp_ll_q, pp_lh_q;
  logic [46:0] pp_hl_q, pp_hh_q;
  logic        neg5_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      pp_ll_q <= mag_q[23:0] * k4_q[23:0];
      pp_lh_q <= mag_q[23:0] * k4_q[47:24];
      pp_hl_q <= mag_q[46:24] * k4_q[23:0];
      pp_hh_q <= mag_q[46:24] * k4_q[47:24];
      neg5_q  <= neg4_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: full product, /2^16 rounded away from zero for negative L
  // (floor of the signed value). A quotient at or above 2^38 - 1 saturates the
  // output anyway, so it clamps to 2^38 - 1; this also covers the huge-product case.
  // ---------------------------------------------------------------------
  logic [48:0] pp_mid;
  logic [94:0] prod_full;
  logic        big, rnd;
  logic [37:0] qmag_q, qmag_d;
  logic        neg6_q;

  assign pp_mid    = {1'b0, pp_lh_q} + {2'b0, pp_hl_q};
  assign prod_full = {pp_hh_q, 48'b0} + {22'b0, pp_mid, 24'b0} + {47'b0, pp_ll_q};
  assign big       = (|prod_full[94:54]) || (&prod_full[53:16]);
  assign rnd       = neg5_q && (|prod_full[15:0]);
  assign qmag_d    = big ? '1 : prod_full[53:16] + {37'b0, rnd};

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      qmag_q <= qmag_d;
      neg6_q <= neg5_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: signed Q, floor /4, bias for the unsigned divide by 3
  // ---------------------------------------------------------------------
  logic signed [38:0] q_s;
  logic signed [36:0] q_d4;
  logic [37:0]        u_q, u_d;

  assign q_s  = neg6_q ? -$signed({1'b0, qmag_q}) : $signed({1'b0, qmag_q});
  assign q_d4 = q_s[38:2];
  assign u_d  = {q_d4[36], q_d4} + awfd_pkg::DIV3_BIAS;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      u_q <= u_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 8-9: t = floor(Q / 12)
  // ---------------------------------------------------------------------
  awfd_pkg::awfd_div_en_t div_en;
  logic signed [36:0]     t_s;

  assign div_en.en_a = en[8];
  assign div_en.en_b = en[9];

  awfd_div3 u_div3 (
    .clk_i (clk_i),
    .en_i  (div_en),
    .u_i   (u_q),
    .t_o   (t_s)
  );

  // ---------------------------------------------------------------------
  // Stage 10: t + 2*curr - prev, saturated to 32 bits; output register
  // ---------------------------------------------------------------------
  logic signed [37:0] sum;
  logic signed [31:0] new_value_d;

  assign sum = 38'(t_s) + 38'(base_q[NSTG-2]);

  always_comb begin
    if (sum[37:31] == 7'b0000000 || sum[37:31] == 7'b1111111) begin
      new_value_d = sum[31:0];
    end else if (sum[37]) begin
      new_value_d = 32'sh8000_0000;
    end else begin
      new_value_d = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTG-1]) begin
      new_value_o <= new_value_d;
    end
  end

endmodule

`default_nettype wire
